// File: rtl/uv_sphere_vertex_generator_defines.svh
// ----------------------------------------------------------------------------
// uv sphere vertex generator assertion macros
// concurrent checks on clk with rst_n low as disable; empty for synthesis
// ----------------------------------------------------------------------------
`ifndef UV_SPHERE_VERTEX_GENERATOR_DEFINES_SVH
`define UV_SPHERE_VERTEX_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define UVSG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("uvsg check failed");
`define UVSG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("uvsg check failed");
`else
`define UVSG_ASSERT(lbl, prop)
`define UVSG_ASSERT_IMP(lbl, ante, cons)
`endif

`endif

// File: rtl/uvsg_pkg.sv
// ----------------------------------------------------------------------------
// uvsg_pkg
// shared constants and the cordic arctangent table
// ----------------------------------------------------------------------------
package uvsg_pkg;

  localparam logic [31:0]        PI_Q30   = 32'hC90FDAA2;
  localparam logic signed [31:0] GAIN_Q30 = 32'sh26DD3B6A;

  localparam int DIV_STAGES = 8;

  // angle divider: (rem*pi + den) / (2*den)
  localparam int ZN_W  = 41;
  localparam int ZD_W  = 10;
  localparam int Z_QB  = 31;
  // texture divider: (idx*2^17 + count) / (2*count)
  localparam int TN_W  = 26;
  localparam int TD_W  = 10;
  localparam int T_QB  = 17;

  localparam logic REG_STACK_COUNT = 1'b0;
  localparam logic REG_SLICE_COUNT = 1'b1;

  function automatic logic [31:0] atan_q30(input logic [4:0] k);
    logic [31:0] v;
    case (k)
      5'd0:    v = 32'h3243F6A8;
      5'd1:    v = 32'h1DAC6705;
      5'd2:    v = 32'h0FADBAFC;
      5'd3:    v = 32'h07F56EA6;
      5'd4:    v = 32'h03FEAB76;
      5'd5:    v = 32'h01FFD55B;
      5'd6:    v = 32'h00FFFAAA;
      5'd7:    v = 32'h007FFF55;
      5'd8:    v = 32'h003FFFEA;
      5'd9:    v = 32'h001FFFFD;
      5'd10:   v = 32'h000FFFFF;
      5'd11:   v = 32'h0007FFFF;
      5'd12:   v = 32'h0003FFFF;
      5'd13:   v = 32'h0001FFFF;
      5'd14:   v = 32'h0000FFFF;
      5'd15:   v = 32'h00007FFF;
      5'd16:   v = 32'h00003FFF;
      5'd17:   v = 32'h00001FFF;
      5'd18:   v = 32'h00000FFF;
      5'd19:   v = 32'h000007FF;
      5'd20:   v = 32'h000003FF;
      5'd21:   v = 32'h000001FF;
      5'd22:   v = 32'h000000FF;
      5'd23:   v = 32'h0000007F;
      5'd24:   v = 32'h0000003F;
      5'd25:   v = 32'h0000001F;
      5'd26:   v = 32'h0000000F;
      5'd27:   v = 32'h00000008;
      5'd28:   v = 32'h00000004;
      5'd29:   v = 32'h00000002;
      5'd30:   v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/uv_sphere_vertex_generator.sv
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator
// Takes one (stack, slice) grid point an item and returns its unit-sphere
// position (q1.15), texture coordinates (q1.16) and quad vertex indices.
// Fully pipelined: one item per cycle while the output is not held, made of
// two front stages, an 8-stage angle and texture divider, one cordic stage
// per step and three output stages.
// The whole pipeline holds while the output register is full and not taken.
// ----------------------------------------------------------------------------
`include "uv_sphere_vertex_generator_defines.svh"

module uv_sphere_vertex_generator import uvsg_pkg::*; #(
  parameter int GRID_BITS    = 8,
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_stack_index,
  input  logic [7:0]  in_slice_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [15:0] out_pos_x,
  output logic signed [15:0] out_pos_y,
  output logic signed [15:0] out_pos_z,
  output logic [16:0] out_tex_u,
  output logic [16:0] out_tex_v,
  output logic [15:0] out_first_vertex,
  output logic [15:0] out_second_vertex,
  output logic        out_starts_quad,
  output logic        out_out_of_grid
);

  localparam int LAT = 5 + DIV_STAGES + CORDIC_STEPS;
  localparam logic [7:0] GRID_MAX = 8'((1 << GRID_BITS) - 1);

  typedef struct packed {
    logic        oog;
    logic        quad;
    logic [1:0]  qt;
    logic [1:0]  qp;
    logic [15:0] first;
    logic [15:0] second;
  } sb_t;

  function automatic logic [GRID_BITS-1:0] clamp_count(input logic [7:0] v);
    logic [7:0] r;
    r = (v > GRID_MAX) ? GRID_MAX : v;
    return r[GRID_BITS-1:0];
  endfunction

  function automatic logic [15:0] sat16(input logic signed [63:0] v);
    logic [15:0] r;
    if (v > 64'sd32767)       r = 16'h7FFF;
    else if (v < -64'sd32768) r = 16'h8000;
    else                      r = v[15:0];
    return r;
  endfunction

  // configuration
  logic [GRID_BITS-1:0] stack_count_r;
  logic [GRID_BITS-1:0] slice_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stack_count_r <= clamp_count(8'd16);
      slice_count_r <= clamp_count(8'd32);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_STACK_COUNT: stack_count_r <= clamp_count(cfg_wdata);
        REG_SLICE_COUNT: slice_count_r <= clamp_count(cfg_wdata);
      endcase
    end
  end

  logic [7:0] st;
  logic [7:0] sl;
  assign st = 8'(stack_count_r);
  assign sl = 8'(slice_count_r);

  logic en;
  logic vld_r [LAT];

  assign en       = !vld_r[LAT-1] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k < LAT; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  // stage 1: grid check, quadrants, indices
  logic [7:0]  j;
  logic [7:0]  i;
  logic [9:0]  j4;
  logic [9:0]  i4;
  logic [9:0]  m1, m2, m3, m4;
  logic [1:0]  qt_nxt;
  logic [1:0]  qp_nxt;
  logic [9:0]  rem_t_nxt;
  logic [9:0]  rem_p_nxt;
  sb_t         sb_nxt;

  assign j  = in_stack_index;
  assign i  = in_slice_index;
  assign j4 = {j, 2'b00};
  assign i4 = {i, 2'b00};
  assign m1 = {2'b00, sl};
  assign m2 = {1'b0, sl, 1'b0};
  assign m3 = m1 + m2;
  assign m4 = {sl, 2'b00};

  always_comb begin
    if (j == st) begin
      qt_nxt    = 2'd2;
      rem_t_nxt = j4 - {st, 2'b00};
    end else if ({j, 1'b0} >= {1'b0, st}) begin
      qt_nxt    = 2'd1;
      rem_t_nxt = j4 - {1'b0, st, 1'b0};
    end else begin
      qt_nxt    = 2'd0;
      rem_t_nxt = j4;
    end
    if (i4 >= m4) begin
      qp_nxt    = 2'd0;
      rem_p_nxt = i4 - m4;
    end else if (i4 >= m3) begin
      qp_nxt    = 2'd3;
      rem_p_nxt = i4 - m3;
    end else if (i4 >= m2) begin
      qp_nxt    = 2'd2;
      rem_p_nxt = i4 - m2;
    end else if (i4 >= m1) begin
      qp_nxt    = 2'd1;
      rem_p_nxt = i4 - m1;
    end else begin
      qp_nxt    = 2'd0;
      rem_p_nxt = i4;
    end
    sb_nxt.oog    = (st == 8'd0) || (sl == 8'd0) || (j > st) || (i > sl);
    sb_nxt.quad   = (j < st) && (i < sl);
    sb_nxt.qt     = qt_nxt;
    sb_nxt.qp     = qp_nxt;
    sb_nxt.first  = 16'(j) * (16'(sl) + 16'd1) + 16'(i);
    sb_nxt.second = sb_nxt.first + 16'(sl) + 16'd1;
  end

  sb_t        sb_r [LAT-1];
  logic [9:0] rem_t_r;
  logic [9:0] rem_p_r;
  logic [TN_W-1:0] tnu_r;
  logic [TN_W-1:0] tnv_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sb_r[0] <= sb_nxt;
      for (int k = 1; k < LAT - 1; k++) sb_r[k] <= sb_r[k-1];
      rem_t_r <= rem_t_nxt;
      rem_p_r <= rem_p_nxt;
      tnu_r   <= TN_W'({i, 17'b0}) + TN_W'(sl);
      tnv_r   <= TN_W'({j, 17'b0}) + TN_W'(st);
    end
  end

  // stage 2: residual angle numerators
  logic [ZN_W-1:0] znt_r;
  logic [ZN_W-1:0] znp_r;
  logic [ZD_W-1:0] zdt_r;
  logic [ZD_W-1:0] zdp_r;
  logic [TN_W-1:0] tnu2_r;
  logic [TN_W-1:0] tnv2_r;
  logic [TD_W-1:0] tdu_r;
  logic [TD_W-1:0] tdv_r;

  always_ff @(posedge clk) begin
    if (en) begin
      znt_r  <= ZN_W'(rem_t_r) * ZN_W'(PI_Q30) + ZN_W'({st, 1'b0});
      znp_r  <= ZN_W'(rem_p_r) * ZN_W'(PI_Q30) + ZN_W'(sl);
      zdt_r  <= ZD_W'({st, 2'b00});
      zdp_r  <= ZD_W'({sl, 1'b0});
      tnu2_r <= tnu_r;
      tnv2_r <= tnv_r;
      tdu_r  <= TD_W'({sl, 1'b0});
      tdv_r  <= TD_W'({st, 1'b0});
    end
  end

  logic [Z_QB-1:0] zt_q;
  logic [Z_QB-1:0] zp_q;
  logic [T_QB-1:0] tu_q;
  logic [T_QB-1:0] tv_q;

  uvsg_div #(.NW(ZN_W), .DW(ZD_W), .QB(Z_QB), .STAGES(DIV_STAGES)) u_div_zt (
    .clk(clk), .en(en), .num(znt_r), .den(zdt_r), .quo(zt_q)
  );
  uvsg_div #(.NW(ZN_W), .DW(ZD_W), .QB(Z_QB), .STAGES(DIV_STAGES)) u_div_zp (
    .clk(clk), .en(en), .num(znp_r), .den(zdp_r), .quo(zp_q)
  );
  uvsg_div #(.NW(TN_W), .DW(TD_W), .QB(T_QB), .STAGES(DIV_STAGES)) u_div_tu (
    .clk(clk), .en(en), .num(tnu2_r), .den(tdu_r), .quo(tu_q)
  );
  uvsg_div #(.NW(TN_W), .DW(TD_W), .QB(T_QB), .STAGES(DIV_STAGES)) u_div_tv (
    .clk(clk), .en(en), .num(tnv2_r), .den(tdv_r), .quo(tv_q)
  );

  // texture coordinates ride along the cordic
  logic [16:0] tu_r [CORDIC_STEPS+2];
  logic [16:0] tv_r [CORDIC_STEPS+2];

  always_ff @(posedge clk) begin
    if (en) begin
      tu_r[0] <= 17'd65536 - tu_q;
      tv_r[0] <= 17'd65536 - tv_q;
      for (int k = 1; k < CORDIC_STEPS + 2; k++) begin
        tu_r[k] <= tu_r[k-1];
        tv_r[k] <= tv_r[k-1];
      end
    end
  end

  logic signed [31:0] xt, yt, xp, yp;

  uvsg_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_t (
    .clk(clk), .en(en), .z_in(signed'({1'b0, zt_q})), .x_out(xt), .y_out(yt)
  );
  uvsg_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_p (
    .clk(clk), .en(en), .z_in(signed'({1'b0, zp_q})), .x_out(xp), .y_out(yp)
  );

  // post 1: quadrant fold, y rounding
  sb_t                sb_q;
  logic signed [31:0] ct_v, sth_v, cp_v, sp_v, py_t;

  assign sb_q = sb_r[1 + DIV_STAGES + CORDIC_STEPS];

  always_comb begin
    case (sb_q.qt)
      2'd0:    begin ct_v = xt;  sth_v = yt;  end
      2'd1:    begin ct_v = -yt; sth_v = xt;  end
      2'd2:    begin ct_v = -xt; sth_v = -yt; end
      default: begin ct_v = yt;  sth_v = -xt; end
    endcase
    case (sb_q.qp)
      2'd0:    begin cp_v = xp;  sp_v = yp;  end
      2'd1:    begin cp_v = -yp; sp_v = xp;  end
      2'd2:    begin cp_v = -xp; sp_v = -yp; end
      default: begin cp_v = yp;  sp_v = -xp; end
    endcase
    py_t = (ct_v + 32'sd16384) >>> 15;
  end

  logic signed [31:0] sth_r, cp_r, sp_r;
  logic [15:0]        py1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sth_r <= sth_v;
      cp_r  <= cp_v;
      sp_r  <= sp_v;
      py1_r <= sat16(64'(py_t));
    end
  end

  // post 2: products
  logic signed [63:0] px_prod_r;
  logic signed [63:0] pz_prod_r;
  logic [15:0]        py2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      px_prod_r <= 64'(cp_r) * 64'(sth_r);
      pz_prod_r <= 64'(sp_r) * 64'(sth_r);
      py2_r     <= py1_r;
    end
  end

  // output register
  sb_t                sb_o;
  logic signed [63:0] px_v;
  logic signed [63:0] pz_v;

  assign sb_o = sb_r[LAT-2];
  assign px_v = (px_prod_r + (64'sd1 <<< 44)) >>> 45;
  assign pz_v = (pz_prod_r + (64'sd1 <<< 44)) >>> 45;

  always_ff @(posedge clk) begin
    if (en) begin
      out_out_of_grid <= sb_o.oog;
      if (sb_o.oog) begin
        out_pos_x         <= '0;
        out_pos_y         <= '0;
        out_pos_z         <= '0;
        out_tex_u         <= '0;
        out_tex_v         <= '0;
        out_first_vertex  <= '0;
        out_second_vertex <= '0;
        out_starts_quad   <= 1'b0;
      end else begin
        out_pos_x         <= sat16(px_v);
        out_pos_y         <= py2_r;
        out_pos_z         <= sat16(pz_v);
        out_tex_u         <= tu_r[CORDIC_STEPS+1];
        out_tex_v         <= tv_r[CORDIC_STEPS+1];
        out_first_vertex  <= sb_o.first;
        out_second_vertex <= sb_o.second;
        out_starts_quad   <= sb_o.quad;
      end
    end
  end

  assign out_valid = vld_r[LAT-1];

  `UVSG_ASSERT_IMP(a_oog_zero, out_valid && out_out_of_grid, out_pos_x == '0 && out_pos_y == '0 && out_pos_z == '0 && out_first_vertex == '0)
  `UVSG_ASSERT_IMP(a_quad_in_grid, out_valid && out_starts_quad, !out_out_of_grid)
  `UVSG_ASSERT_IMP(a_second_offset, out_valid && !out_out_of_grid, out_second_vertex == out_first_vertex + 16'(slice_count_r) + 16'd1)
  `UVSG_ASSERT_IMP(a_tex_range, out_valid, out_tex_u <= 17'd65536 && out_tex_v <= 17'd65536)

endmodule

// File: rtl/uvsg_div.sv
// ----------------------------------------------------------------------------
// uvsg_div
// pipelined restoring divider, ceil(QB/STAGES) quotient bits per stage
// ----------------------------------------------------------------------------
module uvsg_div import uvsg_pkg::*; #(
  parameter int NW     = 41,
  parameter int DW     = 10,
  parameter int QB     = 31,
  parameter int STAGES = 8
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QB-1:0] quo
);

  localparam int SPS = (QB + STAGES - 1) / STAGES;
  localparam int QS  = SPS * STAGES;

  logic [DW-1:0] rem_r [STAGES];
  logic [QS-1:0] lo_r  [STAGES];
  logic [QS-1:0] quo_r [STAGES];
  logic [DW-1:0] den_r [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [DW-1:0] rem_i;
    logic [DW-1:0] den_i;
    logic [QS-1:0] lo_i;
    logic [QS-1:0] quo_i;
    logic [DW-1:0] rem_nxt;
    logic [QS-1:0] lo_nxt;
    logic [QS-1:0] quo_nxt;
    logic [DW:0]   t_v;

    if (s == 0) begin : g_first
      assign rem_i = DW'(num[NW-1:QS]);
      assign lo_i  = num[QS-1:0];
      assign quo_i = '0;
      assign den_i = den;
    end else begin : g_next
      assign rem_i = rem_r[s-1];
      assign lo_i  = lo_r[s-1];
      assign quo_i = quo_r[s-1];
      assign den_i = den_r[s-1];
    end

    always_comb begin
      rem_nxt = rem_i;
      lo_nxt  = lo_i;
      quo_nxt = quo_i;
      t_v     = '0;
      for (int b = 0; b < SPS; b++) begin
        t_v    = {rem_nxt, lo_nxt[QS-1]};
        lo_nxt = {lo_nxt[QS-2:0], 1'b0};
        if (t_v >= {1'b0, den_i}) begin
          t_v     = t_v - {1'b0, den_i};
          quo_nxt = {quo_nxt[QS-2:0], 1'b1};
        end else begin
          quo_nxt = {quo_nxt[QS-2:0], 1'b0};
        end
        rem_nxt = t_v[DW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_nxt;
        lo_r[s]  <= lo_nxt;
        quo_r[s] <= quo_nxt;
        den_r[s] <= den_i;
      end
    end
  end

  assign quo = quo_r[STAGES-1][QB-1:0];

endmodule

// File: rtl/uvsg_cordic.sv
// ----------------------------------------------------------------------------
// uvsg_cordic
// rotation mode cordic, one micro-rotation per pipeline stage, q2.30
// ----------------------------------------------------------------------------
module uvsg_cordic import uvsg_pkg::*; #(
  parameter int STEPS = 16
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] z_in,
  output logic signed [31:0] x_out,
  output logic signed [31:0] y_out
);

  logic signed [31:0] x_r [STEPS];
  logic signed [31:0] y_r [STEPS];
  logic signed [31:0] z_r [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic signed [31:0] x_i;
    logic signed [31:0] y_i;
    logic signed [31:0] z_i;
    logic signed [31:0] at;

    if (k == 0) begin : g_first
      assign x_i = GAIN_Q30;
      assign y_i = '0;
      assign z_i = z_in;
    end else begin : g_next
      assign x_i = x_r[k-1];
      assign y_i = y_r[k-1];
      assign z_i = z_r[k-1];
    end

    assign at = signed'(atan_q30(5'(k)));

    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_i[31]) begin
          x_r[k] <= x_i - (y_i >>> k);
          y_r[k] <= y_i + (x_i >>> k);
          z_r[k] <= z_i - at;
        end else begin
          x_r[k] <= x_i + (y_i >>> k);
          y_r[k] <= y_i - (x_i >>> k);
          z_r[k] <= z_i + at;
        end
      end
    end
  end

  assign x_out = x_r[STEPS-1];
  assign y_out = y_r[STEPS-1];

endmodule

// File: tb/sv/tb_uv_sphere_vertex_generator.sv
// ----------------------------------------------------------------------------
// tb_uv_sphere_vertex_generator
// Streams grid points through the vertex generator under several stack and
// slice counts, with random gaps and stalls on both sides. Each result is
// checked field by field against a bit-exact cordic and divider model.
// ----------------------------------------------------------------------------
module tb_uv_sphere_vertex_generator import uvsg_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  STEPS      = 16;
  localparam int  WDOG_LIMIT = 4000;
  localparam int  TAIL       = 60;
  localparam longint PI_FIX   = 64'd3373259426;
  localparam longint GAIN_FIX = 64'd652032874;
  localparam longint ATAN_TBL [16] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
    64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
    64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF};

  typedef struct {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic [15:0]        first_vertex;
    logic [15:0]        second_vertex;
    logic               starts_quad;
    logic               out_of_grid;
  } vertex_t;

  typedef struct {
    logic [7:0] stack_index;
    logic [7:0] slice_index;
    bit         typed;
  } grid_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_addr;
  logic [7:0]  cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_stack_index;
  logic [7:0]  in_slice_index;
  logic        out_valid;
  logic        out_ready;
  logic signed [15:0] out_pos_x;
  logic signed [15:0] out_pos_y;
  logic signed [15:0] out_pos_z;
  logic [16:0] out_tex_u;
  logic [16:0] out_tex_v;
  logic [15:0] out_first_vertex;
  logic [15:0] out_second_vertex;
  logic        out_starts_quad;
  logic        out_out_of_grid;

  uv_sphere_vertex_generator i_dut (.*);

  vertex_t    vertex_q[$];
  vertex_t    typed_q[$];
  bit         typed_flag_q[$];
  bit         typed_next;
  int unsigned stacks_cfg;
  int unsigned slices_cfg;
  bit         idle_on;
  bit         hold_req;
  bit         failed;
  int         quiet_cycles;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic longint sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // cos and sin (q2.30) of the angle num/den of a full turn
  function automatic void turn_sincos(longint num, longint den,
                                      output longint c, output longint s);
    longint q, rem, z, x, y, nx;
    q   = (4 * num) / den;
    rem = 4 * num - q * den;
    z   = (rem * PI_FIX + den) / (2 * den);
    x   = GAIN_FIX;
    y   = 0;
    for (int k = 0; k < STEPS; k++) begin
      if (z >= 0) begin
        nx = x - (y >>> k);
        y  = y + (x >>> k);
        z  = z - ATAN_TBL[k];
      end else begin
        nx = x + (y >>> k);
        y  = y - (x >>> k);
        z  = z + ATAN_TBL[k];
      end
      x = nx;
    end
    case (q % 4)
      0: begin c = x;  s = y;  end
      1: begin c = -y; s = x;  end
      2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic vertex_t sphere_vertex(logic [7:0] j8, logic [7:0] i8);
    vertex_t r;
    longint j, i, st, sl, ct, stt, cp, sp, first;
    j  = j8;
    i  = i8;
    st = stacks_cfg;
    sl = slices_cfg;
    r  = '{default: '0};
    if (st == 0 || sl == 0 || j > st || i > sl) begin
      r.out_of_grid = 1'b1;
      return r;
    end
    turn_sincos(j, 2 * st, ct, stt);
    turn_sincos(i, sl, cp, sp);
    r.pos_x = 16'(sat16((cp * stt + (longint'(1) << 44)) >>> 45));
    r.pos_y = 16'(sat16((ct + (longint'(1) << 14)) >>> 15));
    r.pos_z = 16'(sat16((sp * stt + (longint'(1) << 44)) >>> 45));
    r.tex_u = 17'(65536 - (i * 131072 + sl) / (2 * sl));
    r.tex_v = 17'(65536 - (j * 131072 + st) / (2 * st));
    first   = j * (sl + 1) + i;
    r.first_vertex  = 16'(first);
    r.second_vertex = 16'(first + sl + 1);
    r.starts_quad   = (j < st && i < sl);
    return r;
  endfunction

  // accepted items and returned results
  always @(posedge clk) begin
    vertex_t e;
    if (rst_n && in_valid && in_ready) begin
      vertex_q.push_back(sphere_vertex(in_stack_index, in_slice_index));
      typed_flag_q.push_back(typed_next);
    end
    if (rst_n && out_valid && out_ready) begin
      if (vertex_q.size() == 0) begin
        $error("result with no item pending");
        failed = 1'b1;
      end else begin
        e = vertex_q.pop_front();
        if (typed_flag_q.pop_front()) e = typed_q.pop_front();
        if (out_pos_x !== e.pos_x) begin
          $error("pos_x exp %0d got %0d", e.pos_x, out_pos_x); failed = 1'b1;
        end
        if (out_pos_y !== e.pos_y) begin
          $error("pos_y exp %0d got %0d", e.pos_y, out_pos_y); failed = 1'b1;
        end
        if (out_pos_z !== e.pos_z) begin
          $error("pos_z exp %0d got %0d", e.pos_z, out_pos_z); failed = 1'b1;
        end
        if (out_tex_u !== e.tex_u) begin
          $error("tex_u exp %0d got %0d", e.tex_u, out_tex_u); failed = 1'b1;
        end
        if (out_tex_v !== e.tex_v) begin
          $error("tex_v exp %0d got %0d", e.tex_v, out_tex_v); failed = 1'b1;
        end
        if (out_first_vertex !== e.first_vertex) begin
          $error("first_vertex exp %0d got %0d", e.first_vertex, out_first_vertex);
          failed = 1'b1;
        end
        if (out_second_vertex !== e.second_vertex) begin
          $error("second_vertex exp %0d got %0d", e.second_vertex, out_second_vertex);
          failed = 1'b1;
        end
        if (out_starts_quad !== e.starts_quad) begin
          $error("starts_quad exp %0d got %0d", e.starts_quad, out_starts_quad);
          failed = 1'b1;
        end
        if (out_out_of_grid !== e.out_of_grid) begin
          $error("out_of_grid exp %0d got %0d", e.out_of_grid, out_out_of_grid);
          failed = 1'b1;
        end
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver with random stall bursts and one long hold
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // entered and left at a falling edge
  task automatic send_point(logic [7:0] j, logic [7:0] i);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_stack_index <= j;
    in_slice_index <= i;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (vertex_q.size() != 0) @(negedge clk);
    repeat (TAIL) @(negedge clk);
  endtask

  task automatic write_counts(int unsigned st, int unsigned sl);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_STACK_COUNT;
    cfg_wdata <= 8'(st);
    @(negedge clk);
    cfg_addr  <= REG_SLICE_COUNT;
    cfg_wdata <= 8'(sl);
    @(negedge clk);
    cfg_we    <= 1'b0;
    stacks_cfg = st;
    slices_cfg = sl;
  endtask

  task automatic random_points(int n);
    logic [7:0] j, i;
    repeat (n) begin
      if ($urandom_range(0, 7) == 0) begin
        j = 8'($urandom_range(0, 255));
        i = 8'($urandom_range(0, 255));
      end else begin
        j = 8'($urandom_range(0, stacks_cfg));
        i = 8'($urandom_range(0, slices_cfg));
      end
      send_point(j, i);
    end
  endtask

  grid_row_t grid_rows[] = '{
    '{8'd0,   8'd0,   1'b0}, '{8'd16,  8'd0,   1'b0}, '{8'd0,   8'd32,  1'b0},
    '{8'd16,  8'd32,  1'b0}, '{8'd15,  8'd31,  1'b0}, '{8'd8,   8'd8,   1'b0},
    '{8'd8,   8'd16,  1'b0}, '{8'd8,   8'd24,  1'b0}, '{8'd4,   8'd7,   1'b0},
    '{8'd12,  8'd25,  1'b0}, '{8'd1,   8'd1,   1'b0}, '{8'd16,  8'd31,  1'b0},
    '{8'd15,  8'd32,  1'b0}, '{8'd17,  8'd0,   1'b1}, '{8'd0,   8'd33,  1'b1},
    '{8'd255, 8'd255, 1'b1}, '{8'd128, 8'd5,   1'b1}, '{8'd3,   8'd170, 1'b1},
    '{8'd85,  8'd85,  1'b1}
  };

  int unsigned phase_st[] = '{1, 255, 255, 1, 0, 7, 200, 3, 255, 1, 60, 9};
  int unsigned phase_sl[] = '{3, 255, 1, 1, 32, 0, 2, 254, 3, 255, 3, 40};

  initial begin
    vertex_t oog;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_addr       = REG_STACK_COUNT;
    cfg_wdata      = 8'd0;
    in_valid       = 1'b0;
    in_stack_index = 8'd0;
    in_slice_index = 8'd0;
    idle_on        = 1'b1;
    hold_req       = 1'b0;
    failed         = 1'b0;
    typed_next     = 1'b0;
    quiet_cycles   = 0;
    stacks_cfg     = 16;
    slices_cfg     = 32;
    oog             = '{default: '0};
    oog.out_of_grid = 1'b1;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset counts
    foreach (grid_rows[k]) begin
      if (grid_rows[k].typed) typed_q.push_back(oog);
      typed_next = grid_rows[k].typed;
      send_point(grid_rows[k].stack_index, grid_rows[k].slice_index);
    end
    typed_next = 1'b0;
    random_points(40);
    wait_drained();

    foreach (phase_st[p]) begin
      write_counts(phase_st[p], phase_sl[p]);
      if (p == 1) hold_req = 1'b1;
      if (p == phase_st.size() - 1) idle_on = 1'b0;
      random_points(110);
      wait_drained();
    end
    write_counts($urandom_range(1, 255), $urandom_range(3, 255));
    random_points(60);
    wait_drained();

    if (!failed) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/uvsg_pkg.sv
rtl/uvsg_div.sv
rtl/uvsg_cordic.sv
rtl/uv_sphere_vertex_generator.sv
tb/sv/tb_uv_sphere_vertex_generator.sv
